// ----- hw/rtl/tlr_pkg.sv -----
// Shared widths, codes and types of the thick line rasterizer.
// No dependencies; imported by tlr_stepper and thick_line_rasterizer.
package tlr_pkg;

	localparam int COORD_BITS  = 16;
	localparam int CANVAS_BITS = 12;

	// Fixed field widths.
	localparam int PEN_W   = 5;
	localparam int HALF_W  = PEN_W - 1;
	localparam int OFS_W   = PEN_W;
	localparam int COLOR_W = 24;
	localparam int ADDR_W  = 24;
	localparam int CFG_W   = 13;

	// Derived internal widths.
	localparam int CUR_W  = COORD_BITS + 1;
	localparam int DX_W   = COORD_BITS + 1;
	localparam int DY_W   = COORD_BITS + 2;
	localparam int ERR_W  = COORD_BITS + 3;
	localparam int PX_W   = COORD_BITS + 2;
	localparam int DIM_W  = CANVAS_BITS + 1;
	localparam int CMP_W  = (PX_W > DIM_W) ? PX_W : DIM_W;
	localparam int PROD_W = CANVAS_BITS + DIM_W + 1;

	// Stream packing.
	localparam int IN_FIELDS_W  = 4 * COORD_BITS + PEN_W + COLOR_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * CANVAS_BITS + ADDR_W + COLOR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = CFG_W'(1440);
	localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = CFG_W'(900);
	localparam logic [DIM_W-1:0] DIM_LIMIT         = DIM_W'(1) << CANVAS_BITS;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_CANVAS_WIDTH  = 1'b0,
		CFG_CANVAS_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic        [PEN_W-1:0]      pen_width;
		logic        [COLOR_W-1:0]    pen_color;
	} load_t;

	typedef struct packed {
		logic                   active;
		logic signed [PX_W-1:0] px;
		logic signed [PX_W-1:0] py;
		logic                   last;
		logic [COLOR_W-1:0]     color;
	} point_t;

endpackage

// ----- hw/rtl/tlr_stepper.sv -----
// Bresenham line state and square-pen stamp walker.
// Depends on tlr_pkg; instantiated by thick_line_rasterizer.
module tlr_stepper
	import tlr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  logic   advance,
	input  load_t  load_data,
	output point_t point
);

	logic                     active_q;
	logic signed [CUR_W-1:0]  cur_x_q, cur_y_q;
	logic signed [COORD_BITS-1:0] tgt_x_q, tgt_y_q;
	logic        [DX_W-1:0]   delta_x_q;
	logic signed [DY_W-1:0]   delta_y_q;
	logic                     neg_x_q, neg_y_q;
	logic signed [ERR_W-1:0]  err_q;
	logic        [HALF_W-1:0] half_q;
	logic signed [OFS_W-1:0]  ofs_x_q, ofs_y_q;
	logic        [COLOR_W-1:0] color_q;

	logic                     active_d;
	logic signed [CUR_W-1:0]  cur_x_d, cur_y_d;
	logic signed [COORD_BITS-1:0] tgt_x_d, tgt_y_d;
	logic        [DX_W-1:0]   delta_x_d;
	logic signed [DY_W-1:0]   delta_y_d;
	logic                     neg_x_d, neg_y_d;
	logic signed [ERR_W-1:0]  err_d;
	logic        [HALF_W-1:0] half_d;
	logic signed [OFS_W-1:0]  ofs_x_d, ofs_y_d;
	logic        [COLOR_W-1:0] color_d;

	logic signed [CUR_W-1:0]  sx, sy, ex, ey;
	logic        [HALF_W-1:0] ld_half;
	logic        [DX_W-1:0]   ld_dx, ld_ady;
	logic signed [DY_W-1:0]   ld_dy;
	logic signed [OFS_W-1:0]  half_s;
	logic                     at_end, stamp_done;
	logic signed [ERR_W:0]    twice;
	logic                     step_x, step_y;
	logic signed [ERR_W-1:0]  err_add_x, err_add_y;

	always_comb begin
		sx = CUR_W'(load_data.start_x);
		sy = CUR_W'(load_data.start_y);
		ex = CUR_W'(load_data.end_x);
		ey = CUR_W'(load_data.end_y);
		ld_dx  = (ex > sx) ? DX_W'(ex - sx) : DX_W'(sx - ex);
		ld_ady = (ey > sy) ? DX_W'(ey - sy) : DX_W'(sy - ey);
		ld_dy  = -$signed(DY_W'(ld_ady));
		ld_half = load_data.pen_width[PEN_W-1:1];

		half_s     = $signed(OFS_W'(half_q));
		at_end     = (cur_x_q == CUR_W'(tgt_x_q)) && (cur_y_q == CUR_W'(tgt_y_q));
		stamp_done = (ofs_x_q == half_s) && (ofs_y_q == half_s);

		// Bresenham decision on twice the error term.
		twice  = {err_q, 1'b0};
		step_x = twice >= (ERR_W+1)'(delta_y_q);
		step_y = twice <= $signed((ERR_W+1)'(delta_x_q));
		err_add_x = step_x ? ERR_W'(delta_y_q) : '0;
		err_add_y = step_y ? $signed(ERR_W'(delta_x_q)) : '0;

		active_d  = active_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		tgt_x_d   = tgt_x_q;
		tgt_y_d   = tgt_y_q;
		delta_x_d = delta_x_q;
		delta_y_d = delta_y_q;
		neg_x_d   = neg_x_q;
		neg_y_d   = neg_y_q;
		err_d     = err_q;
		half_d    = half_q;
		ofs_x_d   = ofs_x_q;
		ofs_y_d   = ofs_y_q;
		color_d   = color_q;

		if (load) begin
			active_d  = 1'b1;
			cur_x_d   = sx;
			cur_y_d   = sy;
			tgt_x_d   = load_data.end_x;
			tgt_y_d   = load_data.end_y;
			delta_x_d = ld_dx;
			delta_y_d = ld_dy;
			neg_x_d   = !(sx < ex);
			neg_y_d   = !(sy < ey);
			err_d     = $signed(ERR_W'(ld_dx)) + ERR_W'(ld_dy);
			half_d    = ld_half;
			ofs_x_d   = -$signed(OFS_W'(ld_half));
			ofs_y_d   = -$signed(OFS_W'(ld_half));
			color_d   = load_data.pen_color;
		end else if (advance && active_q) begin
			if (ofs_x_q < half_s) begin
				ofs_x_d = ofs_x_q + OFS_W'(1);
			end else begin
				ofs_x_d = -half_s;
				if (ofs_y_q < half_s) begin
					ofs_y_d = ofs_y_q + OFS_W'(1);
				end else begin
					ofs_y_d = -half_s;
					if (at_end) begin
						active_d = 1'b0;
					end else begin
						err_d = err_q + err_add_x + err_add_y;
						if (step_x) begin
							cur_x_d = neg_x_q ? cur_x_q - CUR_W'(1) : cur_x_q + CUR_W'(1);
						end
						if (step_y) begin
							cur_y_d = neg_y_q ? cur_y_q - CUR_W'(1) : cur_y_q + CUR_W'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			neg_x_q   <= 1'b0;
			neg_y_q   <= 1'b0;
			err_q     <= '0;
			half_q    <= '0;
			ofs_x_q   <= '0;
			ofs_y_q   <= '0;
			color_q   <= '0;
		end else begin
			active_q  <= active_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			tgt_x_q   <= tgt_x_d;
			tgt_y_q   <= tgt_y_d;
			delta_x_q <= delta_x_d;
			delta_y_q <= delta_y_d;
			neg_x_q   <= neg_x_d;
			neg_y_q   <= neg_y_d;
			err_q     <= err_d;
			half_q    <= half_d;
			ofs_x_q   <= ofs_x_d;
			ofs_y_q   <= ofs_y_d;
			color_q   <= color_d;
		end
	end

	always_comb begin
		point.active = active_q;
		point.px     = PX_W'(cur_x_q) + PX_W'(ofs_x_q);
		point.py     = PX_W'(cur_y_q) + PX_W'(ofs_y_q);
		point.last   = at_end && stamp_done;
		point.color  = color_q;
	end

endmodule

// ----- hw/rtl/thick_line_rasterizer.sv -----
// Top level of the thick line rasterizer: stream ports, canvas registers,
// clipping stage and address stage. Depends on tlr_pkg and tlr_stepper.
//
//   Channel   Direction  Handshake          Carries
//   s_*       in         tvalid/tready      line load or advance command
//   m_*       out        tvalid/tready      one pen pixel (tuser = write enable)
//   cfg_*     in         cfg_we             canvas width and height
//
// One item is accepted per cycle; an advance that produces a pixel passes
// the clip stage and the address multiply into the output register before m_*
// shows it. Loads and advances while idle produce nothing. The line state is
// updated at acceptance, so back-to-back advances run at one pixel per clock.
// Reset clears the line engine to idle and sets the canvas to 1440 by 900.
// A stall on m_tready holds both stages and drops s_tready once they are full.
module thick_line_rasterizer
	import tlr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_x, start_y, end_x, end_y, pen_width, pen_color, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_x, pixel_y, pixel_address, pixel_color
	output logic [OUT_DATA_W-1:0] m_tdata,
	// write_enable
	output logic                  m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0] canvas_w_q, canvas_h_q;
	logic [DIM_W-1:0] cw, ch;

	load_t  load_data;
	point_t point;
	logic   accept, load, advance;

	logic             valid_s1, valid_s2;
	logic             adv_s1, adv_s2;
	logic [CANVAS_BITS-1:0] px_s1, py_s1, px_s2, py_s2;
	logic             inside_s1, inside_s2, last_s1, last_s2;
	logic [COLOR_W-1:0] color_s1, color_s2;
	logic [DIM_W-1:0] cw_s1;
	logic [ADDR_W-1:0] addr_s2;

	logic signed [CMP_W-1:0] px_ext, py_ext;
	logic             in_canvas;
	logic [PROD_W-1:0] addr_full;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
		logic [CMP_W:0] dx;
		logic [CMP_W:0] lim;
		dx  = (CMP_W+1)'(d);
		lim = (CMP_W+1)'(DIM_LIMIT);
		return (dx > lim) ? DIM_LIMIT : DIM_W'(dx);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= CANVAS_WIDTH_RST;
			canvas_h_q <= CANVAS_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data;
				CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign cw = clamp_dim(canvas_w_q);
	assign ch = clamp_dim(canvas_h_q);

	assign load_data.start_x   = s_tdata[0*COORD_BITS +: COORD_BITS];
	assign load_data.start_y   = s_tdata[1*COORD_BITS +: COORD_BITS];
	assign load_data.end_x     = s_tdata[2*COORD_BITS +: COORD_BITS];
	assign load_data.end_y     = s_tdata[3*COORD_BITS +: COORD_BITS];
	assign load_data.pen_width = s_tdata[4*COORD_BITS +: PEN_W];
	assign load_data.pen_color = s_tdata[4*COORD_BITS+PEN_W +: COLOR_W];

	// The output register frees when it is empty or being taken.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign accept   = s_tvalid && s_tready;
	assign load     = accept && (cmd_t'(s_tuser) == CMD_LOAD);
	assign advance  = accept && (cmd_t'(s_tuser) == CMD_ADVANCE);

	tlr_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.advance   (advance),
		.load_data (load_data),
		.point     (point)
	);

	always_comb begin
		px_ext = CMP_W'(point.px);
		py_ext = CMP_W'(point.py);
		in_canvas = !point.px[PX_W-1] && !point.py[PX_W-1]
			&& ($unsigned(px_ext) < CMP_W'(cw))
			&& ($unsigned(py_ext) < CMP_W'(ch));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= advance && point.active;
		end
	end

	// Clipped pixels carry zero coordinates, which makes their address zero too.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			px_s1     <= in_canvas ? px_ext[CANVAS_BITS-1:0] : '0;
			py_s1     <= in_canvas ? py_ext[CANVAS_BITS-1:0] : '0;
			inside_s1 <= in_canvas;
			last_s1   <= point.last;
			color_s1  <= point.color;
			cw_s1     <= cw;
		end
	end

	assign addr_full = PROD_W'(py_s1) * PROD_W'(cw_s1) + PROD_W'(px_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			addr_s2   <= ADDR_W'(addr_full);
			color_s2  <= color_s1;
			inside_s2 <= inside_s1;
			last_s2   <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_DATA_W'({color_s2, addr_s2, py_s2, px_s2});
	assign m_tuser  = inside_s2;
	assign m_tlast  = last_s2;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for thick_line_rasterizer: stream driver, stream monitor and
// an in-bench pixel predictor, with directed lines, random lines and canvas changes.
// Depends on tlr_pkg and the thick_line_rasterizer RTL only.
module tb_top;
	import tlr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 8;

	typedef struct {
		cmd_t  cmd;
		load_t ld;
	} line_cmd_t;

	typedef struct packed {
		logic [CANVAS_BITS-1:0] x;
		logic [CANVAS_BITS-1:0] y;
		logic [ADDR_W-1:0]      addr;
		logic [COLOR_W-1:0]     color;
		logic                   we;
		logic                   last;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [CFG_W-1:0]      cfg_data = '0;

	thick_line_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted line engine state.
	logic [CFG_W-1:0]        canvas_w = CANVAS_WIDTH_RST;
	logic [CFG_W-1:0]        canvas_h = CANVAS_HEIGHT_RST;
	bit                      line_active = 1'b0;
	logic signed [CUR_W-1:0] pos_x = '0, pos_y = '0;
	logic signed [COORD_BITS-1:0] goal_x = '0, goal_y = '0;
	logic signed [DX_W-1:0]  span_x = '0;
	logic signed [DY_W-1:0]  span_y = '0;
	bit                      dir_x_neg = 1'b0, dir_y_neg = 1'b0;
	logic signed [ERR_W-1:0] bres_err = '0;
	logic [HALF_W-1:0]       pen_half = '0;
	logic signed [OFS_W-1:0] stamp_dx = '0, stamp_dy = '0;
	logic [COLOR_W-1:0]      ink = '0;

	pixel_t    pixels_due[$];
	line_cmd_t cmds_to_send[$];
	line_cmd_t next_cmd;
	load_t     seen_ld;
	pixel_t    want_pix;

	int  stim_count = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  gen_w = 1440, gen_h = 900;
	bit  src_idle_on = 1'b1, sink_idle_on = 1'b1;
	int  src_gap = 0, sink_gap = 0;
	bit  hold_req = 1'b0, hold_done = 1'b0;
	int  hold_left = 0;

	function automatic void rasterize_item(input cmd_t cmd, input load_t ld);
		int sx, sy, ex, ey, px, py, cw, ch, twice, e, h, ox, oy;
		bit in_canvas, at_end, stamp_done;
		pixel_t pix;
		if (cmd == CMD_LOAD) begin
			sx = int'(ld.start_x);
			sy = int'(ld.start_y);
			ex = int'(ld.end_x);
			ey = int'(ld.end_y);
			pos_x = CUR_W'(sx);
			pos_y = CUR_W'(sy);
			goal_x = ld.end_x;
			goal_y = ld.end_y;
			span_x = DX_W'(ex > sx ? ex - sx : sx - ex);
			span_y = DY_W'(-(ey > sy ? ey - sy : sy - ey));
			dir_x_neg = !(sx < ex);
			dir_y_neg = !(sy < ey);
			bres_err = ERR_W'(int'(span_x) + int'(span_y));
			pen_half = HALF_W'(ld.pen_width >> 1);
			stamp_dx = OFS_W'(-int'(pen_half));
			stamp_dy = OFS_W'(-int'(pen_half));
			ink = ld.pen_color;
			line_active = 1'b1;
			return;
		end
		if (!line_active)
			return;

		h = int'(pen_half);
		ox = int'(stamp_dx);
		oy = int'(stamp_dy);
		px = int'(pos_x) + ox;
		py = int'(pos_y) + oy;
		cw = int'(canvas_w);
		ch = int'(canvas_h);
		if (cw > (1 << CANVAS_BITS))
			cw = 1 << CANVAS_BITS;
		if (ch > (1 << CANVAS_BITS))
			ch = 1 << CANVAS_BITS;
		in_canvas = px >= 0 && py >= 0 && px < cw && py < ch;
		at_end = int'(pos_x) == int'(goal_x) && int'(pos_y) == int'(goal_y);
		stamp_done = ox == h && oy == h;

		pix.x = in_canvas ? CANVAS_BITS'(px) : '0;
		pix.y = in_canvas ? CANVAS_BITS'(py) : '0;
		pix.addr = in_canvas ? ADDR_W'(py * cw + px) : '0;
		pix.color = ink;
		pix.we = in_canvas;
		pix.last = at_end && stamp_done;
		pixels_due.push_back(pix);

		// Columns run fastest, then rows; a finished stamp moves the line point.
		if (ox < h) begin
			stamp_dx = OFS_W'(ox + 1);
		end else begin
			stamp_dx = OFS_W'(-h);
			if (oy < h) begin
				stamp_dy = OFS_W'(oy + 1);
			end else begin
				stamp_dy = OFS_W'(-h);
				if (at_end) begin
					line_active = 1'b0;
				end else begin
					e = int'(bres_err);
					twice = 2 * e;
					if (twice >= int'(span_y)) begin
						e += int'(span_y);
						pos_x = CUR_W'(int'(pos_x) + (dir_x_neg ? -1 : 1));
					end
					if (twice <= int'(span_x)) begin
						e += int'(span_x);
						pos_y = CUR_W'(int'(pos_y) + (dir_y_neg ? -1 : 1));
					end
					bres_err = ERR_W'(e);
				end
			end
		end
	endfunction

	function automatic void push_load(input int sx, input int sy, input int ex, input int ey,
			input int pen, input logic [COLOR_W-1:0] color);
		line_cmd_t c;
		c.cmd = CMD_LOAD;
		c.ld.start_x = COORD_BITS'(sx);
		c.ld.start_y = COORD_BITS'(sy);
		c.ld.end_x = COORD_BITS'(ex);
		c.ld.end_y = COORD_BITS'(ey);
		c.ld.pen_width = PEN_W'(pen);
		c.ld.pen_color = color;
		cmds_to_send.push_back(c);
		stim_count++;
	endfunction

	// Advances carry random payload, which the block must ignore.
	function automatic void push_advances(input int n);
		line_cmd_t c;
		repeat (n) begin
			c.cmd = CMD_ADVANCE;
			c.ld = IN_FIELDS_W'({$urandom, $urandom, $urandom});
			cmds_to_send.push_back(c);
			stim_count++;
		end
	endfunction

	function automatic int near_edge(input int dim);
		return int'($urandom_range(0, dim + 8)) - 4;
	endfunction

	// One line, mostly near the canvas and drawn to the end, else cut short by the next load.
	function automatic void queue_random_line();
		int sx, sy, ex, ey, pen, side, len, npix, n;
		if ($urandom_range(0, 9) == 0) begin
			push_load($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 31),
				COLOR_W'($urandom));
			push_advances($urandom_range(0, 3));
			return;
		end
		sx = near_edge(gen_w);
		sy = near_edge(gen_h);
		ex = sx + int'($urandom_range(0, 12)) - 6;
		ey = sy + int'($urandom_range(0, 12)) - 6;
		case ($urandom_range(0, 19))
			0: pen = $urandom_range(30, 31);
			1, 2, 3, 4: pen = $urandom_range(4, 9);
			default: pen = $urandom_range(0, 3);
		endcase
		side = 2 * (pen / 2) + 1;
		len = (ex > sx ? ex - sx : sx - ex);
		if ((ey > sy ? ey - sy : sy - ey) > len)
			len = (ey > sy ? ey - sy : sy - ey);
		npix = side * side * (len + 1);
		push_load(sx, sy, ex, ey, pen, COLOR_W'($urandom));
		if (npix > 150 || $urandom_range(0, 6) == 0)
			n = $urandom_range(1, npix > 60 ? 60 : npix);
		else
			n = npix + $urandom_range(0, 2);
		push_advances(n);
	endfunction

	function automatic void queue_random_lines(input int count);
		int stop_at;
		stop_at = stim_count + count;
		while (stim_count < stop_at)
			queue_random_line();
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Waits until every item is taken and every pixel is back, then lets the pipeline settle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (cmds_to_send.size() != 0 || s_tvalid || pixels_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_canvas(input int w, input int h);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= CFG_CANVAS_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_w = w > 4096 ? 4096 : w;
		gen_h = h > 4096 ? 4096 : h;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sender: offers queued items with random gaps between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (cmds_to_send.size() != 0) begin
				next_cmd = cmds_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_cmd.cmd;
				s_tdata <= IN_DATA_W'({next_cmd.ld.pen_color, next_cmd.ld.pen_width,
					next_cmd.ld.end_y, next_cmd.ld.end_x, next_cmd.ld.start_y,
					next_cmd.ld.start_x});
				if (src_idle_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 14);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (sink_idle_on && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 14);
		end
	end

	// Tracks register writes and accepted items, and predicts the pixels they cause.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_CANVAS_WIDTH)
					canvas_w = cfg_data;
				else
					canvas_h = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				seen_ld.start_x = s_tdata[0 +: COORD_BITS];
				seen_ld.start_y = s_tdata[COORD_BITS +: COORD_BITS];
				seen_ld.end_x = s_tdata[2 * COORD_BITS +: COORD_BITS];
				seen_ld.end_y = s_tdata[3 * COORD_BITS +: COORD_BITS];
				seen_ld.pen_width = s_tdata[4 * COORD_BITS +: PEN_W];
				seen_ld.pen_color = s_tdata[4 * COORD_BITS + PEN_W +: COLOR_W];
				rasterize_item(cmd_t'(s_tuser), seen_ld);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel with none expected: tdata %0h we %0b last %0b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want_pix = pixels_due.pop_front();
				check_field("pixel_x", want_pix.x, m_tdata[0 +: CANVAS_BITS]);
				check_field("pixel_y", want_pix.y, m_tdata[CANVAS_BITS +: CANVAS_BITS]);
				check_field("pixel_address", want_pix.addr,
					m_tdata[2 * CANVAS_BITS +: ADDR_W]);
				check_field("pixel_color", want_pix.color,
					m_tdata[2 * CANVAS_BITS + ADDR_W +: COLOR_W]);
				check_field("write_enable", want_pix.we, m_tuser);
				check_field("last", want_pix.last, m_tlast);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines on the reset canvas.
		push_advances(1);
		push_load(5, 5, 5, 5, 0, 24'hFFFFFF);
		push_advances(2);
		push_load(-32768, 32767, 32767, -32768, 31, 24'h000000);
		push_advances(1);
		// A load in the middle of a line replaces it; this stamp hangs off the corner.
		push_load(0, 0, 0, 0, 3, 24'hA5A5A5);
		push_advances(9);
		push_load(1439, 899, 1440, 900, 1, 24'h5A5A5A);
		push_advances(2);
		push_load(2, 0, 0, 3, 0, 24'h123456);
		push_advances(4);
		wait_idle();

		write_canvas(64, 48);
		queue_random_lines(220);
		wait_idle();

		// Oversized width is clamped to the largest canvas.
		write_canvas(8191, 4096);
		queue_random_lines(120);
		wait_idle();

		write_canvas(4096, 8191);
		sink_idle_on = 1'b0;
		queue_random_lines(80);
		wait_idle();
		sink_idle_on = 1'b1;

		write_canvas(0, 1);
		queue_random_lines(60);
		wait_idle();

		write_canvas(1, 0);
		src_idle_on = 1'b0;
		queue_random_lines(60);
		wait_idle();
		src_idle_on = 1'b1;

		// Long receiver hold-off while the sender keeps pushing lines.
		write_canvas($urandom_range(8, 40), $urandom_range(4, 30));
		queue_random_lines(200);
		hold_req <= 1'b1;
		wait_idle();

		// Final stretch at full rate.
		write_canvas($urandom_range(20, 100), $urandom_range(20, 100));
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		queue_random_lines(260);
		wait_idle();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- thick_line_rasterizer.f -----
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_stepper.sv
hw/rtl/thick_line_rasterizer.sv
sim/tb_top.sv
